### hw/rtl/db4dwt_pkg.sv
// Shared types, constants and coefficient quantization for the db4 2D DWT.
// No dependencies; used by every other file of the block.
package db4dwt_pkg;

    localparam int DEF_MAX_COLS       = 1024;
    localparam int DEF_MAX_ROWS       = 1024;
    localparam int DEF_COEF_FRAC_BITS = 15;

    localparam int TAPS       = 8;
    localparam int SAMPLE_W   = 16;
    localparam int ROW_RES_W  = 21;
    localparam int COEF_OUT_W = 22;
    localparam int IDX_W      = 9;
    localparam int CFG_W      = 11;
    localparam int CFG_ADDR_W = 4;

    localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_WIDTH  = 4'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_HEIGHT = 4'd1;
    localparam logic [CFG_W-1:0]      WIDTH_RESET      = 11'd512;
    localparam logic [CFG_W-1:0]      HEIGHT_RESET     = 11'd512;

    localparam longint DEC_SCALE = 64'd1000000000000000;

    // analysis filters, decimal constants scaled by 1e15
    localparam longint LO_E15 [TAPS] = '{
        -64'sd10597401785069,  64'sd32883011666885,  64'sd30841381835560,
        -64'sd187034811719093, -64'sd27983769416984, 64'sd630880767929590,
        64'sd714846570552542,  64'sd230377813308897
    };
    localparam longint HI_E15 [TAPS] = '{
        -64'sd230377813308897, 64'sd714846570552542, -64'sd630880767929590,
        -64'sd27983769416984,  64'sd187034811719093, 64'sd30841381835560,
        -64'sd32883011666885,  -64'sd10597401785069
    };

    typedef struct packed {
        logic       shift;
        logic       row_mac;
        logic       row_first;
        logic       wr;
        logic       rd;
        logic       col_mac;
        logic       col_first;
        logic       load_out;
        logic [2:0] tap;
    } cmd_t;

    // round to nearest of e15 * 2^frac / 1e15, evaluated at elaboration
    function automatic longint quantize(longint e15, int frac);
        longint mag;
        longint q;
        mag = (e15 < 0) ? -e15 : e15;
        q = 0;
        for (int i = 0; i <= frac; i++)
        begin
            mag = mag <<< 1;
            q = q <<< 1;
            if (mag >= DEC_SCALE)
            begin
                mag = mag - DEC_SCALE;
                q = q | 64'sd1;
            end
        end
        q = (q + 64'sd1) >>> 1;
        return (e15 < 0) ? -q : q;
    endfunction

endpackage

### hw/rtl/db4dwt_if.sv
// Stream interfaces for samples, coefficient sets and register writes.
// Depends on db4dwt_pkg for field widths.
interface db4dwt_in_if;
    logic                                    valid;
    logic                                    ready;
    logic signed [db4dwt_pkg::SAMPLE_W-1:0]  sample;
    modport source (output valid, output sample, input ready);
    modport sink (input valid, input sample, output ready);
endinterface

interface db4dwt_out_if;
    logic                                      valid;
    logic                                      ready;
    logic signed [db4dwt_pkg::COEF_OUT_W-1:0]  ll;
    logic signed [db4dwt_pkg::COEF_OUT_W-1:0]  lh;
    logic signed [db4dwt_pkg::COEF_OUT_W-1:0]  hl;
    logic signed [db4dwt_pkg::COEF_OUT_W-1:0]  hh;
    logic [db4dwt_pkg::IDX_W-1:0]              out_row;
    logic [db4dwt_pkg::IDX_W-1:0]              out_col;
    logic                                      frame_last;
    modport source (output valid, output ll, output lh, output hl, output hh,
                    output out_row, output out_col, output frame_last, input ready);
    modport sink (input valid, input ll, input lh, input hl, input hh,
                  input out_row, input out_col, input frame_last, output ready);
endinterface

interface db4dwt_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [db4dwt_pkg::CFG_ADDR_W-1:0]   addr;
    logic [db4dwt_pkg::CFG_W-1:0]        data;
    modport source (output valid, output addr, output data, input ready);
    modport sink (input valid, input addr, input data, output ready);
endinterface

### hw/rtl/db4dwt_ctrl.sv
// Sequencer: config registers, raster counters and the per-item state machine.
// Depends on db4dwt_pkg; drives db4dwt_dp through a cmd_t bundle.
module db4dwt_ctrl #(
    parameter int MAX_COLS = db4dwt_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS = db4dwt_pkg::DEF_MAX_ROWS,
    localparam int PW      = $clog2(MAX_COLS / 2)
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    input  logic [db4dwt_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [db4dwt_pkg::CFG_W-1:0]    cfg_data,
    output logic                            cfg_ready,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            out_busy,
    output db4dwt_pkg::cmd_t                cmd,
    output logic [2:0]                      slot,
    output logic [PW-1:0]                   pos,
    output logic [db4dwt_pkg::IDX_W-1:0]    orow,
    output logic                            last
);
    localparam int CNTW = $clog2(MAX_COLS);
    localparam int RCW  = $clog2(MAX_ROWS);
    localparam int WW   = $clog2((MAX_COLS > MAX_ROWS ? MAX_COLS : MAX_ROWS) + 1);
    localparam int CMPW = (WW > db4dwt_pkg::CFG_W ? WW : db4dwt_pkg::CFG_W) + 1;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_ROW  = 3'd1;
    localparam logic [2:0] S_WR   = 3'd2;
    localparam logic [2:0] S_COL  = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    logic [2:0]                    state_reg, state_next;
    logic [3:0]                    cnt_reg, cnt_next;
    logic [CNTW-1:0]               c_reg, c_next;
    logic [RCW-1:0]                r_reg, r_next;
    logic [db4dwt_pkg::CFG_W-1:0]  width_reg, height_reg;
    logic [2:0]                    slot_reg, slot_next;
    logic [PW-1:0]                 pos_reg, pos_next;
    logic [db4dwt_pkg::IDX_W-1:0]  orow_reg, orow_next;
    logic                          last_reg, last_next;
    logic                          colhit_reg, colhit_next;

    logic [CMPW-1:0] wx, hx, w_eff, h_eff, cx, rx;
    logic [CNTW-1:0] cm7;
    logic [RCW-1:0]  rm7;
    logic            accept, row_hit, col_hit;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= db4dwt_pkg::WIDTH_RESET;
            height_reg <= db4dwt_pkg::HEIGHT_RESET;
        end
        else if (cfg_valid)
        begin
            if (cfg_addr == db4dwt_pkg::REG_IMAGE_WIDTH)
                width_reg <= cfg_data;
            else if (cfg_addr == db4dwt_pkg::REG_IMAGE_HEIGHT)
                height_reg <= cfg_data;
        end
    end

    always_comb
    begin
        wx = CMPW'(width_reg);
        hx = CMPW'(height_reg);
        if (wx < CMPW'(8))
            w_eff = CMPW'(8);
        else if (wx > CMPW'(MAX_COLS))
            w_eff = CMPW'(MAX_COLS);
        else
            w_eff = wx;
        if (hx < CMPW'(8))
            h_eff = CMPW'(8);
        else if (hx > CMPW'(MAX_ROWS))
            h_eff = CMPW'(MAX_ROWS);
        else
            h_eff = hx;
        cx = CMPW'(c_reg);
        rx = CMPW'(r_reg);
    end

    assign cm7     = c_reg - CNTW'(7);
    assign rm7     = r_reg - RCW'(7);
    assign row_hit = (c_reg >= CNTW'(7)) && c_reg[0];
    assign col_hit = row_hit && (r_reg >= RCW'(7)) && r_reg[0];

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        c_next      = c_reg;
        r_next      = r_reg;
        slot_next   = slot_reg;
        pos_next    = pos_reg;
        orow_next   = orow_reg;
        last_next   = last_reg;
        colhit_next = colhit_reg;
        cmd         = '0;
        slot        = slot_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.shift   = 1'b1;
                    slot_next   = r_reg[2:0];
                    pos_next    = PW'(cm7[CNTW-1:1]);
                    orow_next   = db4dwt_pkg::IDX_W'(rm7[RCW-1:1]);
                    last_next   = (cx + CMPW'(2) >= w_eff) && (rx + CMPW'(2) >= h_eff);
                    colhit_next = col_hit;
                    cnt_next    = '0;
                    if (row_hit)
                        state_next = S_ROW;
                    // advance raster position
                    if (cx + CMPW'(1) >= w_eff)
                    begin
                        c_next = '0;
                        r_next = (rx + CMPW'(1) >= h_eff) ? '0 : r_reg + RCW'(1);
                    end
                    else
                        c_next = c_reg + CNTW'(1);
                end
            end
            S_ROW:
            begin
                cmd.row_mac   = 1'b1;
                cmd.row_first = (cnt_reg == 4'd0);
                cmd.tap       = cnt_reg[2:0];
                cnt_next      = cnt_reg + 4'd1;
                if (cnt_reg == 4'd7)
                    state_next = S_WR;
            end
            S_WR:
            begin
                cmd.wr   = 1'b1;
                cnt_next = '0;
                state_next = colhit_reg ? S_COL : S_IDLE;
            end
            S_COL:
            begin
                // read slot k while accumulating slot k-1
                slot = slot_reg + 3'd1 + cnt_reg[2:0];
                cmd.rd = (cnt_reg != 4'd8);
                cmd.col_mac   = (cnt_reg != 4'd0);
                cmd.col_first = (cnt_reg == 4'd1);
                cmd.tap       = cnt_reg[2:0] - 3'd1;
                cnt_next      = cnt_reg + 4'd1;
                if (cnt_reg == 4'd8)
                    state_next = S_FIN;
            end
            S_FIN:
            begin
                if (!out_busy)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            cnt_reg    <= '0;
            c_reg      <= '0;
            r_reg      <= '0;
            colhit_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            c_reg      <= c_next;
            r_reg      <= r_next;
            colhit_reg <= colhit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
        pos_reg  <= pos_next;
        orow_reg <= orow_next;
        last_reg <= last_next;
    end

    assign pos  = pos_reg;
    assign orow = orow_reg;
    assign last = last_reg;
endmodule

### hw/rtl/db4dwt_dp.sv
// Datapath: sample window, row and column MAC units, line stores, output register.
// Depends on db4dwt_pkg; sequenced by db4dwt_ctrl.
module db4dwt_dp #(
    parameter int MAX_COLS       = db4dwt_pkg::DEF_MAX_COLS,
    parameter int COEF_FRAC_BITS = db4dwt_pkg::DEF_COEF_FRAC_BITS,
    localparam int PW            = $clog2(MAX_COLS / 2)
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  db4dwt_pkg::cmd_t                          cmd,
    input  logic [2:0]                                slot,
    input  logic [PW-1:0]                             pos,
    input  logic [db4dwt_pkg::IDX_W-1:0]              orow,
    input  logic                                      last,
    input  logic signed [db4dwt_pkg::SAMPLE_W-1:0]    sample,
    input  logic                                      out_ready,
    output logic                                      out_busy,
    output logic                                      out_valid,
    output logic signed [db4dwt_pkg::COEF_OUT_W-1:0]  ll,
    output logic signed [db4dwt_pkg::COEF_OUT_W-1:0]  lh,
    output logic signed [db4dwt_pkg::COEF_OUT_W-1:0]  hl,
    output logic signed [db4dwt_pkg::COEF_OUT_W-1:0]  hh,
    output logic [db4dwt_pkg::IDX_W-1:0]              out_row,
    output logic [db4dwt_pkg::IDX_W-1:0]              out_col,
    output logic                                      frame_last
);
    localparam int F        = COEF_FRAC_BITS;
    localparam int CW       = F + 2;
    localparam int SW       = db4dwt_pkg::SAMPLE_W;
    localparam int RW       = db4dwt_pkg::ROW_RES_W;
    localparam int OW       = db4dwt_pkg::COEF_OUT_W;
    localparam int RAW      = SW + CW + 3;
    localparam int CAW      = RW + CW + 3;
    localparam int LINE_LEN = MAX_COLS / 2;
    localparam int DEPTH    = db4dwt_pkg::TAPS * LINE_LEN;
    localparam int AW       = $clog2(DEPTH);

    localparam logic signed [CW-1:0] LO_Q [8] = '{
        CW'(db4dwt_pkg::quantize(db4dwt_pkg::LO_E15[0], F)),
        CW'(db4dwt_pkg::quantize(db4dwt_pkg::LO_E15[1], F)),
        CW'(db4dwt_pkg::quantize(db4dwt_pkg::LO_E15[2], F)),
        CW'(db4dwt_pkg::quantize(db4dwt_pkg::LO_E15[3], F)),
        CW'(db4dwt_pkg::quantize(db4dwt_pkg::LO_E15[4], F)),
        CW'(db4dwt_pkg::quantize(db4dwt_pkg::LO_E15[5], F)),
        CW'(db4dwt_pkg::quantize(db4dwt_pkg::LO_E15[6], F)),
        CW'(db4dwt_pkg::quantize(db4dwt_pkg::LO_E15[7], F))
    };
    localparam logic signed [CW-1:0] HI_Q [8] = '{
        CW'(db4dwt_pkg::quantize(db4dwt_pkg::HI_E15[0], F)),
        CW'(db4dwt_pkg::quantize(db4dwt_pkg::HI_E15[1], F)),
        CW'(db4dwt_pkg::quantize(db4dwt_pkg::HI_E15[2], F)),
        CW'(db4dwt_pkg::quantize(db4dwt_pkg::HI_E15[3], F)),
        CW'(db4dwt_pkg::quantize(db4dwt_pkg::HI_E15[4], F)),
        CW'(db4dwt_pkg::quantize(db4dwt_pkg::HI_E15[5], F)),
        CW'(db4dwt_pkg::quantize(db4dwt_pkg::HI_E15[6], F)),
        CW'(db4dwt_pkg::quantize(db4dwt_pkg::HI_E15[7], F))
    };

    localparam logic signed [RAW-1:0] HALF_R = RAW'(64'sd1 <<< (F - 5));
    localparam logic signed [RAW-1:0] RMAX   = RAW'((64'sd1 <<< (RW - 1)) - 64'sd1);
    localparam logic signed [RAW-1:0] RMIN   = RAW'(-(64'sd1 <<< (RW - 1)));
    localparam logic signed [CAW-1:0] HALF_C = CAW'(64'sd1 <<< (F - 1));
    localparam logic signed [CAW-1:0] CMAX   = CAW'((64'sd1 <<< (OW - 1)) - 64'sd1);
    localparam logic signed [CAW-1:0] CMIN   = CAW'(-(64'sd1 <<< (OW - 1)));

    logic signed [SW-1:0]     win_reg [8];
    logic signed [RAW-1:0]    acc_lo_reg, acc_hi_reg;
    logic signed [SW+CW-1:0]  prod_rlo, prod_rhi;
    logic signed [RAW-1:0]    rs_lo, rs_hi;
    logic signed [RW-1:0]     row_lo, row_hi;
    logic signed [RW-1:0]     low_mem  [DEPTH];
    logic signed [RW-1:0]     high_mem [DEPTH];
    logic signed [RW-1:0]     rd_low_reg, rd_high_reg;
    logic [AW-1:0]            addr;
    logic signed [RW+CW-1:0]  p_ll, p_lh, p_hl, p_hh;
    logic signed [CAW-1:0]    acc_ll_reg, acc_lh_reg, acc_hl_reg, acc_hh_reg;
    logic                     out_valid_reg, out_valid_next;
    logic signed [OW-1:0]     ll_reg, lh_reg, hl_reg, hh_reg;
    logic [db4dwt_pkg::IDX_W-1:0] orow_out_reg, ocol_out_reg;
    logic                     last_out_reg;

    function automatic logic signed [RW-1:0] round_row(logic signed [RAW-1:0] a);
        logic signed [RAW-1:0] s;
        s = (a + HALF_R) >>> (F - 4);
        if (s > RMAX)
            return RW'(RMAX);
        else if (s < RMIN)
            return RW'(RMIN);
        return RW'(s);
    endfunction

    function automatic logic signed [OW-1:0] round_col(logic signed [CAW-1:0] a);
        logic signed [CAW-1:0] s;
        s = (a + HALF_C) >>> F;
        if (s > CMAX)
            return OW'(CMAX);
        else if (s < CMIN)
            return OW'(CMIN);
        return OW'(s);
    endfunction

    always_ff @(posedge clk)
    begin
        if (cmd.shift)
        begin
            for (int k = 0; k < 7; k++)
                win_reg[k] <= win_reg[k + 1];
            win_reg[7] <= sample;
        end
    end

    assign prod_rlo = win_reg[cmd.tap] * LO_Q[cmd.tap];
    assign prod_rhi = win_reg[cmd.tap] * HI_Q[cmd.tap];

    always_ff @(posedge clk)
    begin
        if (cmd.row_mac)
        begin
            acc_lo_reg <= (cmd.row_first ? '0 : acc_lo_reg) + RAW'(prod_rlo);
            acc_hi_reg <= (cmd.row_first ? '0 : acc_hi_reg) + RAW'(prod_rhi);
        end
    end

    assign rs_lo  = acc_lo_reg;
    assign rs_hi  = acc_hi_reg;
    assign row_lo = round_row(rs_lo);
    assign row_hi = round_row(rs_hi);
    assign addr   = AW'(slot) * AW'(LINE_LEN) + AW'(pos);

    always_ff @(posedge clk)
    begin
        if (cmd.wr)
        begin
            low_mem[addr]  <= row_lo;
            high_mem[addr] <= row_hi;
        end
        if (cmd.rd)
        begin
            rd_low_reg  <= low_mem[addr];
            rd_high_reg <= high_mem[addr];
        end
    end

    assign p_ll = rd_low_reg  * LO_Q[cmd.tap];
    assign p_lh = rd_low_reg  * HI_Q[cmd.tap];
    assign p_hl = rd_high_reg * LO_Q[cmd.tap];
    assign p_hh = rd_high_reg * HI_Q[cmd.tap];

    always_ff @(posedge clk)
    begin
        if (cmd.col_mac)
        begin
            acc_ll_reg <= (cmd.col_first ? '0 : acc_ll_reg) + CAW'(p_ll);
            acc_lh_reg <= (cmd.col_first ? '0 : acc_lh_reg) + CAW'(p_lh);
            acc_hl_reg <= (cmd.col_first ? '0 : acc_hl_reg) + CAW'(p_hl);
            acc_hh_reg <= (cmd.col_first ? '0 : acc_hh_reg) + CAW'(p_hh);
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            ll_reg       <= round_col(acc_ll_reg);
            lh_reg       <= round_col(acc_lh_reg);
            hl_reg       <= round_col(acc_hl_reg);
            hh_reg       <= round_col(acc_hh_reg);
            orow_out_reg <= orow;
            ocol_out_reg <= db4dwt_pkg::IDX_W'(pos);
            last_out_reg <= last;
        end
    end

    assign out_busy   = out_valid_reg && !out_ready;
    assign out_valid  = out_valid_reg;
    assign ll         = ll_reg;
    assign lh         = lh_reg;
    assign hl         = hl_reg;
    assign hh         = hh_reg;
    assign out_row    = orow_out_reg;
    assign out_col    = ocol_out_reg;
    assign frame_last = last_out_reg;
endmodule

### hw/rtl/db4_forward_dwt_2d.sv
// One-level 2D db4 forward DWT. An item without a row result is accepted in S_IDLE
// and leaves the block ready for the next item; one with a row result runs the row
// MAC and then the line-store write; one that ends a coefficient set also runs the
// column MAC over the single line-store read port and one output load, waiting while
// the output stalls. rst_n clears counters, state and output valid, sets width and
// height to 512; stores not cleared.
module db4_forward_dwt_2d #(
    parameter int MAX_COLS       = db4dwt_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS       = db4dwt_pkg::DEF_MAX_ROWS,
    parameter int COEF_FRAC_BITS = db4dwt_pkg::DEF_COEF_FRAC_BITS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    db4dwt_in_if.sink            samples,
    db4dwt_out_if.source         coefs,
    db4dwt_cfg_if.sink           cfg
);
    localparam int PW = $clog2(MAX_COLS / 2);

    db4dwt_pkg::cmd_t              cmd;
    logic [2:0]                    slot;
    logic [PW-1:0]                 pos;
    logic [db4dwt_pkg::IDX_W-1:0]  orow;
    logic                          last;
    logic                          out_busy;

    db4dwt_ctrl #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg.valid),
        .cfg_addr  (cfg.addr),
        .cfg_data  (cfg.data),
        .cfg_ready (cfg.ready),
        .in_valid  (samples.valid),
        .in_ready  (samples.ready),
        .out_busy  (out_busy),
        .cmd       (cmd),
        .slot      (slot),
        .pos       (pos),
        .orow      (orow),
        .last      (last)
    );

    db4dwt_dp #(
        .MAX_COLS       (MAX_COLS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .slot       (slot),
        .pos        (pos),
        .orow       (orow),
        .last       (last),
        .sample     (samples.sample),
        .out_ready  (coefs.ready),
        .out_busy   (out_busy),
        .out_valid  (coefs.valid),
        .ll         (coefs.ll),
        .lh         (coefs.lh),
        .hl         (coefs.hl),
        .hh         (coefs.hh),
        .out_row    (coefs.out_row),
        .out_col    (coefs.out_col),
        .frame_last (coefs.frame_last)
    );

`ifndef ASSERT_OFF
    a_one_phase: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.shift, cmd.row_mac, cmd.wr, cmd.load_out}))
        else $error("more than one datapath phase active");

    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.wr && cmd.rd))
        else $error("line store written and read in one cycle");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> !(coefs.valid && !coefs.ready))
        else $error("output loaded while previous item still stalled");

    a_load_after_col: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> !samples.ready)
        else $error("output loaded while accepting samples");
`endif
endmodule
